// File: rtl/qwc_pkg.sv
package qwc_pkg;

   // block dimensions
   localparam int WHEELS_DEFAULT = 4;
   localparam int PIN_WIDTH      = 4;
   localparam int WORD_WIDTH     = 32;
   localparam int SEL_WIDTH      = 2;

   // register indexes of the configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WHEEL_ENABLE     = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIRECTION_INVERT = 1'b1;

   // item operations
   localparam logic OP_PIN_SAMPLE   = 1'b0;
   localparam logic OP_SPEED_SAMPLE = 1'b1;

   // rate arithmetic: ticks times one thousand, then an unsigned long division
   localparam int MS_PER_SECOND = 1000;
   localparam int SCALE_WIDTH   = 10;
   localparam int PRODUCT_WIDTH = WORD_WIDTH + SCALE_WIDTH;
   localparam int COUNT_WIDTH   = $clog2(PRODUCT_WIDTH + 1);

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // one classified transaction on its way to the back
   typedef struct packed {
      logic                         divide;
      logic signed [WORD_WIDTH-1:0] ticks;
      logic signed [WORD_WIDTH-1:0] delta;
      logic        [WORD_WIDTH-1:0] elapsed;
   } qwc_entry_type;

endpackage

// File: rtl/qwc_req_if.sv
interface qwc_req_if;
   logic                            valid;
   logic                            ready;
   logic                            operation;
   logic [qwc_pkg::PIN_WIDTH-1:0]   pin_a;
   logic [qwc_pkg::PIN_WIDTH-1:0]   pin_b;
   logic [qwc_pkg::SEL_WIDTH-1:0]   wheel_select;
   logic [qwc_pkg::WORD_WIDTH-1:0]  now_ms;

   modport source (output valid, operation, pin_a, pin_b, wheel_select, now_ms,
                   input ready);
   modport sink   (input valid, operation, pin_a, pin_b, wheel_select, now_ms,
                   output ready);
endinterface

// File: rtl/qwc_rsp_if.sv
interface qwc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [qwc_pkg::WORD_WIDTH-1:0] tick_count;
   logic signed [qwc_pkg::WORD_WIDTH-1:0] ticks_per_second;
   logic                                  speed_valid;

   modport source (output valid, tick_count, ticks_per_second, speed_valid,
                   input ready);
   modport sink   (input valid, tick_count, ticks_per_second, speed_valid,
                   output ready);
endinterface

// File: rtl/qwc_queue.sv
module qwc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  qwc_pkg::qwc_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output qwc_pkg::qwc_entry_type head_entry
);

   qwc_pkg::qwc_entry_type              slot_ff [qwc_pkg::QUEUE_DEPTH];
   logic [qwc_pkg::QPTR_WIDTH-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [qwc_pkg::QPTR_WIDTH-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [qwc_pkg::QCNT_WIDTH-1:0]      count_ff, count_in;

   assign full       = (count_ff == qwc_pkg::QCNT_WIDTH'(qwc_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == qwc_pkg::QPTR_WIDTH'(qwc_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == qwc_pkg::QPTR_WIDTH'(qwc_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // fill level never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= qwc_pkg::QCNT_WIDTH'(qwc_pkg::QUEUE_DEPTH))
      else $error("queue fill level beyond depth");

endmodule

// File: rtl/qwc_front.sv
module qwc_front #(
   parameter int WHEELS = qwc_pkg::WHEELS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   qwc_req_if.sink                              req_bus,
   input  logic                                 csr_write_enable,
   input  logic [qwc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [qwc_pkg::PIN_WIDTH-1:0]        csr_write_data,
   input  logic                                 queue_full,
   output logic                                 push,
   output qwc_pkg::qwc_entry_type               push_entry
);

   localparam int W = qwc_pkg::WORD_WIDTH;

   logic [qwc_pkg::PIN_WIDTH-1:0] enable_ff;
   logic [qwc_pkg::PIN_WIDTH-1:0] invert_ff;

   logic [W-1:0] ticks_ff      [WHEELS];
   logic [W-1:0] ticks_in      [WHEELS];
   logic [W-1:0] snap_ticks_ff [WHEELS];
   logic [W-1:0] snap_ticks_in [WHEELS];
   logic [W-1:0] snap_time_ff  [WHEELS];
   logic [W-1:0] snap_time_in  [WHEELS];
   logic [WHEELS-1:0] prev_a_ff, prev_a_in;

   logic [WHEELS-1:0] en_vec, inv_vec, a_vec, b_vec;
   logic              accept;
   logic              sel_ok;
   logic              sel_en;
   logic [W-1:0]      sel_ticks, sel_snap_ticks, sel_snap_time;
   logic [W-1:0]      ticks_out, elapsed;
   logic              take_first, take_rate;

   // bits beyond the pin width never belong to a wheel
   assign en_vec  = WHEELS'(enable_ff);
   assign inv_vec = WHEELS'(invert_ff);
   assign a_vec   = WHEELS'(req_bus.pin_a);
   assign b_vec   = WHEELS'(req_bus.pin_b);

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && !queue_full;
   assign sel_ok        = int'(req_bus.wheel_select) < WHEELS;

   // x1 edge counting on every enabled wheel
   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         ticks_in[i]  = ticks_ff[i];
         prev_a_in[i] = prev_a_ff[i];
         if (req_bus.operation == qwc_pkg::OP_PIN_SAMPLE && en_vec[i]) begin
            if (a_vec[i] && !prev_a_ff[i]) begin
               if ((a_vec[i] == b_vec[i]) ^ inv_vec[i]) begin
                  ticks_in[i] = ticks_ff[i] - 1'b1;
               end else begin
                  ticks_in[i] = ticks_ff[i] + 1'b1;
               end
            end
            prev_a_in[i] = a_vec[i];
         end
      end
   end

   // selected wheel view
   always_comb begin
      sel_en         = 1'b0;
      sel_ticks      = '0;
      sel_snap_ticks = '0;
      sel_snap_time  = '0;
      for (int i = 0; i < WHEELS; i++) begin
         if (i == int'(req_bus.wheel_select)) begin
            sel_en         = en_vec[i];
            sel_ticks      = ticks_in[i];
            sel_snap_ticks = snap_ticks_ff[i];
            sel_snap_time  = snap_time_ff[i];
         end
      end
   end

   assign ticks_out = (sel_ok && sel_en) ? sel_ticks : '0;
   assign elapsed   = req_bus.now_ms - sel_snap_time;

   // classify the speed sample: first snapshot, real rate or nothing
   assign take_first = (req_bus.operation == qwc_pkg::OP_SPEED_SAMPLE) && sel_ok
                       && (sel_snap_time == '0);
   assign take_rate  = (req_bus.operation == qwc_pkg::OP_SPEED_SAMPLE) && sel_ok
                       && (sel_snap_time != '0) && (elapsed != '0);

   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         snap_ticks_in[i] = snap_ticks_ff[i];
         snap_time_in[i]  = snap_time_ff[i];
         if ((take_first || take_rate) && i == int'(req_bus.wheel_select)) begin
            snap_ticks_in[i] = ticks_out;
            snap_time_in[i]  = req_bus.now_ms;
         end
      end
   end

   assign push               = accept;
   assign push_entry.divide  = take_rate;
   assign push_entry.ticks   = ticks_out;
   assign push_entry.delta   = ticks_out - sel_snap_ticks;
   assign push_entry.elapsed = elapsed;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         invert_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            qwc_pkg::CSR_WHEEL_ENABLE:     enable_ff <= csr_write_data;
            qwc_pkg::CSR_DIRECTION_INVERT: invert_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // wheel state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff <= '0;
         for (int i = 0; i < WHEELS; i++) begin
            ticks_ff[i]      <= '0;
            snap_ticks_ff[i] <= '0;
            snap_time_ff[i]  <= '0;
         end
      end else if (accept) begin
         prev_a_ff <= prev_a_in;
         for (int i = 0; i < WHEELS; i++) begin
            ticks_ff[i]      <= ticks_in[i];
            snap_ticks_ff[i] <= snap_ticks_in[i];
            snap_time_ff[i]  <= snap_time_in[i];
         end
      end
   end

endmodule

// File: rtl/qwc_back.sv
module qwc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  qwc_pkg::qwc_entry_type head_entry,
   output logic                   pop,
   qwc_rsp_if.source              rsp_bus
);

   localparam int W  = qwc_pkg::WORD_WIDTH;
   localparam int PW = qwc_pkg::PRODUCT_WIDTH;
   localparam int CW = qwc_pkg::COUNT_WIDTH;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ABS  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [PW-1:0]       num_ff, num_in;
   logic [W-1:0]        rem_ff, rem_in;
   logic [W-1:0]        dt_ff, dt_in;
   logic                neg_ff, neg_in;
   logic [W-1:0]        hold_ticks_ff, hold_ticks_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]        rsp_ticks_ff, rsp_ticks_in;
   logic [W-1:0]        rsp_speed_ff, rsp_speed_in;
   logic                rsp_sv_ff, rsp_sv_in;

   logic                out_free;
   logic                load;
   logic [W:0]          trial;
   logic [W:0]          trial_diff;
   logic [W-1:0]        sat_speed;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // one restoring division step
   assign trial      = {rem_ff, num_ff[PW-1]};
   assign trial_diff = trial - {1'b0, dt_ff};

   // sign and saturation of the finished quotient
   always_comb begin
      if (neg_ff) begin
         sat_speed = (num_ff >= PW'(64'h8000_0000)) ? 32'h8000_0000
                                                     : W'(~num_ff + 1'b1);
      end else begin
         sat_speed = (num_ff >= PW'(64'h8000_0000)) ? 32'h7FFF_FFFF : W'(num_ff);
      end
   end

   // sequencer of the rate unit and the output register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      prod_in       = prod_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      dt_in         = dt_ff;
      neg_in        = neg_ff;
      hold_ticks_in = hold_ticks_ff;
      pop           = 1'b0;
      load          = 1'b0;
      rsp_ticks_in  = rsp_ticks_ff;
      rsp_speed_in  = rsp_speed_ff;
      rsp_sv_in     = rsp_sv_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid && head_entry.divide) begin
               pop           = 1'b1;
               prod_in       = PW'(head_entry.delta) * $signed(PW'(qwc_pkg::MS_PER_SECOND));
               dt_in         = head_entry.elapsed;
               hold_ticks_in = head_entry.ticks;
               state_in      = ST_ABS;
            end else if (head_valid && out_free) begin
               pop          = 1'b1;
               load         = 1'b1;
               rsp_ticks_in = head_entry.ticks;
               rsp_speed_in = '0;
               rsp_sv_in    = 1'b0;
            end
         end
         ST_ABS: begin
            neg_in   = prod_ff[PW-1];
            num_in   = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
            rem_in   = '0;
            count_in = CW'(PW);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!trial_diff[W]) begin
               rem_in = trial_diff[W-1:0];
               num_in = {num_ff[PW-2:0], 1'b1};
            end else begin
               rem_in = trial[W-1:0];
               num_in = {num_ff[PW-2:0], 1'b0};
            end
            count_in = count_ff - 1'b1;
            if (count_ff == CW'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_ticks_in = hold_ticks_ff;
               rsp_speed_in = sat_speed;
               rsp_sv_in    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      dt_ff         <= dt_in;
      neg_ff        <= neg_in;
      hold_ticks_ff <= hold_ticks_in;
      if (load) begin
         rsp_ticks_ff <= rsp_ticks_in;
         rsp_speed_ff <= rsp_speed_in;
         rsp_sv_ff    <= rsp_sv_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.tick_count       = rsp_ticks_ff;
   assign rsp_bus.ticks_per_second = rsp_speed_ff;
   assign rsp_bus.speed_valid      = rsp_sv_ff;

   // division steps only run with iterations left
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (count_ff != '0))
      else $error("division step with no iterations left");

   // a result without a real speed carries zero speed
   a_zero_speed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_sv_ff) |-> (rsp_speed_ff == '0))
      else $error("speed reported without speed_valid");

   // queue only drained when it holds an entry
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   // a finished quotient leaves the divider for the done state
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && count_ff == CW'(1)) |=> (state_ff == ST_DONE))
      else $error("division did not finish");

endmodule

// File: rtl/quadrature_wheel_counter.sv
// quadrature wheel counter: x1 decoder for up to WHEELS encoders with a rate sampler
// req_bus carries transactions: operation 0 is a pin sample of every wheel's A and B,
// operation 1 is a speed sample of the wheel named by wheel_select at time now_ms.
// rsp_bus returns one transaction per request, in order: tick_count of the selected
// wheel, ticks_per_second and speed_valid.
// csr_write_enable/csr_index/csr_write_data write wheel_enable (index 0) and
// direction_invert (index 1); write them only while the block is idle.
// a result passes through the queue and then the output register, unless it waits
// behind a rate computation. pin samples and speed samples without a computed rate
// go at one per cycle while the receiver is ready and no rate computation is ahead.
// a speed sample with a computed rate holds the back end for a multiply, a magnitude
// step and 42 steps of the bit-per-cycle restoring divider, then the output load.
// the front keeps taking transactions until the two-entry queue fills.
// reset (synchronous, active high) clears counters, snapshots, previous A levels,
// both registers, the queue, the back-end state and the output valid flag.
// when the receiver stalls the result holds in the output register, the back end
// waits, and req_bus.ready drops once the queue is full.
module quadrature_wheel_counter #(
   parameter int WHEELS = qwc_pkg::WHEELS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   qwc_req_if.sink                              req_bus,
   qwc_rsp_if.source                            rsp_bus,
   input  logic                                 csr_write_enable,
   input  logic [qwc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [qwc_pkg::PIN_WIDTH-1:0]        csr_write_data
);

   logic                   queue_full;
   logic                   push;
   qwc_pkg::qwc_entry_type push_entry;
   logic                   pop;
   logic                   head_valid;
   qwc_pkg::qwc_entry_type head_entry;

   // classification and wheel state
   qwc_front #(
      .WHEELS (WHEELS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   // decoupling queue
   qwc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // rate unit and output register
   qwc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

// File: bench/tb_top.sv
module tb_top;

   localparam int     WHEEL_COUNT = qwc_pkg::WHEELS_DEFAULT;
   localparam int     STALL_LIMIT = 3000;
   localparam int     LONG_HOLD   = 400;
   localparam longint RATE_MAX    = 64'sd2147483647;
   localparam longint RATE_MIN    = -64'sd2147483648;

   // one request transaction and the result it should produce
   typedef struct packed {
      logic                           op;
      logic [qwc_pkg::PIN_WIDTH-1:0]  pin_a;
      logic [qwc_pkg::PIN_WIDTH-1:0]  pin_b;
      logic [qwc_pkg::SEL_WIDTH-1:0]  sel;
      logic [qwc_pkg::WORD_WIDTH-1:0] now_ms;
   } wheel_item_type;

   typedef struct packed {
      logic signed [qwc_pkg::WORD_WIDTH-1:0] tick_count;
      logic signed [qwc_pkg::WORD_WIDTH-1:0] rate;
      logic                                  speed_valid;
   } wheel_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_write_enable = 1'b0;
   logic [qwc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [qwc_pkg::PIN_WIDTH-1:0]       csr_write_data = '0;

   logic           req_valid = 1'b0;
   wheel_item_type req_item = '0;
   logic           rsp_ready = 1'b0;

   qwc_req_if req_bus ();
   qwc_rsp_if rsp_bus ();

   assign req_bus.valid        = req_valid;
   assign req_bus.operation    = req_item.op;
   assign req_bus.pin_a        = req_item.pin_a;
   assign req_bus.pin_b        = req_item.pin_b;
   assign req_bus.wheel_select = req_item.sel;
   assign req_bus.now_ms       = req_item.now_ms;
   assign rsp_bus.ready        = rsp_ready;

   quadrature_wheel_counter #(.WHEELS(WHEEL_COUNT)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predicted decoder state and register copies
   logic [WHEEL_COUNT-1:0][qwc_pkg::WORD_WIDTH-1:0] mdl_ticks = '0;
   logic [WHEEL_COUNT-1:0]                          mdl_prev_a = '0;
   logic [WHEEL_COUNT-1:0][qwc_pkg::WORD_WIDTH-1:0] mdl_snap_ticks = '0;
   logic [WHEEL_COUNT-1:0][qwc_pkg::WORD_WIDTH-1:0] mdl_snap_time = '0;
   logic [qwc_pkg::PIN_WIDTH-1:0]                   mdl_enable = '0;
   logic [qwc_pkg::PIN_WIDTH-1:0]                   mdl_invert = '0;

   wheel_item_type   pending_samples[$];
   wheel_result_type expected_readings[$];

   // stimulus generator state: quadrature phase per wheel and a running clock
   logic [WHEEL_COUNT-1:0][1:0]        gen_quad = '0;
   logic [WHEEL_COUNT-1:0]             gen_dir = '0;
   logic [qwc_pkg::WORD_WIDTH-1:0]     gen_now = 32'd1;
   logic [qwc_pkg::SEL_WIDTH-1:0]      gen_last_sel = '0;

   bit mismatch_seen = 1'b0;
   bit req_burst     = 1'b0;
   bit rsp_burst     = 1'b0;
   int req_wait      = 0;
   int hold_left     = 0;
   int results_seen  = 0;
   int stall_cycles  = 0;

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int draw_gap(bit burst);
      return burst ? 0 : $urandom_range(0, 13);
   endfunction

   // expected result of one transaction, updating the predicted state
   task automatic predict_wheels(input wheel_item_type it, output wheel_result_type res);
      int                             w;
      logic [qwc_pkg::WORD_WIDTH-1:0] seen;
      logic [qwc_pkg::WORD_WIDTH-1:0] elapsed;
      longint                         delta;
      longint                         rate;
      bit                             down;
      res = '0;
      if (it.op == qwc_pkg::OP_PIN_SAMPLE) begin
         for (w = 0; w < WHEEL_COUNT; w++) begin
            if (mdl_enable[w]) begin
               if (it.pin_a[w] && !mdl_prev_a[w]) begin
                  down = (it.pin_a[w] == it.pin_b[w]) ^ mdl_invert[w];
                  mdl_ticks[w] = mdl_ticks[w] + (down ? 32'hFFFF_FFFF : 32'd1);
               end
               mdl_prev_a[w] = it.pin_a[w];
            end
         end
         res.tick_count = mdl_enable[it.sel] ? mdl_ticks[it.sel] : '0;
      end else begin
         seen = mdl_enable[it.sel] ? mdl_ticks[it.sel] : '0;
         res.tick_count = seen;
         if (mdl_snap_time[it.sel] == '0) begin
            // no snapshot yet: take one, no rate
            mdl_snap_time[it.sel]  = it.now_ms;
            mdl_snap_ticks[it.sel] = seen;
         end else begin
            elapsed = it.now_ms - mdl_snap_time[it.sel];
            if (elapsed != '0) begin
               delta = longint'($signed(seen - mdl_snap_ticks[it.sel]));
               rate  = (delta * 1000) / longint'({32'd0, elapsed});
               if (rate > RATE_MAX) rate = RATE_MAX;
               if (rate < RATE_MIN) rate = RATE_MIN;
               res.rate        = rate[qwc_pkg::WORD_WIDTH-1:0];
               res.speed_valid = 1'b1;
               mdl_snap_ticks[it.sel] = seen;
               mdl_snap_time[it.sel]  = it.now_ms;
            end
         end
      end
   endtask

   // request driver: one transaction held until accepted, then a drawn gap
   always @(posedge clock) begin : request_driver
      wheel_result_type predicted;
      if (!reset) begin
         if (req_valid && req_bus.ready) begin
            predict_wheels(req_item, predicted);
            expected_readings.push_back(predicted);
         end
         if (!req_valid || req_bus.ready) begin
            if (req_wait > 0) begin
               req_wait  <= req_wait - 1;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_item  <= pending_samples.pop_front();
               req_valid <= 1'b1;
               req_wait  <= draw_gap(req_burst);
               if ($urandom_range(0, 39) == 0) req_burst <= !req_burst;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare against the oldest expectation, then draw a hold-off
   always @(posedge clock) begin : result_monitor
      wheel_result_type want;
      int               w;
      if (!reset) begin
         if (rsp_bus.valid && rsp_ready) begin
            results_seen = results_seen + 1;
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected result: tick_count %0d rate %0d valid %0b",
                        $time, rsp_bus.tick_count, rsp_bus.ticks_per_second,
                        rsp_bus.speed_valid);
               mismatch_seen = 1'b1;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_bus.tick_count !== want.tick_count) begin
                  $display("%0t: tick_count expected %0d actual %0d",
                           $time, want.tick_count, rsp_bus.tick_count);
                  mismatch_seen = 1'b1;
               end
               if (rsp_bus.ticks_per_second !== want.rate) begin
                  $display("%0t: ticks_per_second expected %0d actual %0d",
                           $time, want.rate, rsp_bus.ticks_per_second);
                  mismatch_seen = 1'b1;
               end
               if (rsp_bus.speed_valid !== want.speed_valid) begin
                  $display("%0t: speed_valid expected %0b actual %0b",
                           $time, want.speed_valid, rsp_bus.speed_valid);
                  mismatch_seen = 1'b1;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_bus.valid && rsp_ready) begin
            // long back-pressure twice in the run so the request side fills up
            w = (results_seen == 300 || results_seen == 650) ? LONG_HOLD
                                                             : draw_gap(rsp_burst);
            if ($urandom_range(0, 39) == 0) rsp_burst <= !rsp_burst;
            if (w > 0) begin
               rsp_ready <= 1'b0;
               hold_left <= w - 1;
            end else begin
               rsp_ready <= 1'b1;
            end
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_readings.size() != 0);
   endtask

   // register writes, only with nothing in flight
   task automatic program_wheels(input logic [qwc_pkg::PIN_WIDTH-1:0] en,
                                 input logic [qwc_pkg::PIN_WIDTH-1:0] inv);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= qwc_pkg::CSR_WHEEL_ENABLE;
      csr_write_data   <= en;
      @(posedge clock);
      csr_index        <= qwc_pkg::CSR_DIRECTION_INVERT;
      csr_write_data   <= inv;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mdl_enable = en;
      mdl_invert = inv;
      @(negedge clock);
   endtask

   task automatic queue_pin(input logic [qwc_pkg::PIN_WIDTH-1:0] a,
                            input logic [qwc_pkg::PIN_WIDTH-1:0] b,
                            input logic [qwc_pkg::SEL_WIDTH-1:0] sel);
      wheel_item_type it;
      it.op     = qwc_pkg::OP_PIN_SAMPLE;
      it.pin_a  = a;
      it.pin_b  = b;
      it.sel    = sel;
      it.now_ms = $urandom;
      pending_samples.push_back(it);
   endtask

   task automatic queue_speed(input logic [qwc_pkg::SEL_WIDTH-1:0] sel,
                              input logic [qwc_pkg::WORD_WIDTH-1:0] now);
      wheel_item_type it;
      it.op     = qwc_pkg::OP_SPEED_SAMPLE;
      it.pin_a  = qwc_pkg::PIN_WIDTH'($urandom);
      it.pin_b  = qwc_pkg::PIN_WIDTH'($urandom);
      it.sel    = sel;
      it.now_ms = now;
      pending_samples.push_back(it);
   endtask

   // mostly clean quadrature motion with rate requests, some noise
   task automatic queue_random_items(input int count);
      int k;
      int w;
      int r;
      int m;
      wheel_item_type it;
      for (w = 0; w < WHEEL_COUNT; w++) gen_dir[w] = 1'($urandom_range(0, 1));
      for (k = 0; k < count; k++) begin
         r         = $urandom_range(0, 99);
         it.op     = qwc_pkg::OP_PIN_SAMPLE;
         it.pin_a  = qwc_pkg::PIN_WIDTH'($urandom);
         it.pin_b  = qwc_pkg::PIN_WIDTH'($urandom);
         it.sel    = qwc_pkg::SEL_WIDTH'($urandom_range(0, 3));
         it.now_ms = $urandom;
         if (r < 14) begin
            it.op = qwc_pkg::OP_SPEED_SAMPLE;
            m     = $urandom_range(0, 9);
            if (m == 0) begin
               // same wheel, same time: zero elapsed
               it.sel    = gen_last_sel;
               it.now_ms = gen_now;
            end else if (m == 1) begin
               gen_now   = $urandom;
               it.now_ms = gen_now;
            end else if (m == 2) begin
               gen_now   = '0;
               it.now_ms = gen_now;
            end else begin
               gen_now   = gen_now + $urandom_range(1, 60);
               it.now_ms = gen_now;
            end
            gen_last_sel = it.sel;
         end else if (r >= 24) begin
            for (w = 0; w < WHEEL_COUNT; w++) begin
               m = $urandom_range(0, 5);
               if (m >= 2 && m <= 4)
                  gen_quad[w] = gen_dir[w] ? gen_quad[w] + 2'd1 : gen_quad[w] - 2'd1;
               else if (m == 5)
                  gen_quad[w] = gen_dir[w] ? gen_quad[w] - 2'd1 : gen_quad[w] + 2'd1;
               it.pin_a[w] = gen_quad[w][0] ^ gen_quad[w][1];
               it.pin_b[w] = gen_quad[w][1];
            end
         end
         pending_samples.push_back(it);
      end
   endtask

   // stimulus sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: edges in both directions, first sample, zero and wrapped elapsed time
      program_wheels(4'hF, 4'h0);
      queue_pin(4'h0, 4'h0, 2'd0);
      queue_pin(4'hF, 4'h0, 2'd0);
      queue_pin(4'h0, 4'hF, 2'd1);
      queue_pin(4'hF, 4'hF, 2'd2);
      queue_pin(4'hF, 4'hF, 2'd3);
      queue_pin(4'h0, 4'h0, 2'd0);
      queue_pin(4'h5, 4'hA, 2'd0);
      queue_speed(2'd0, 32'd0);
      queue_speed(2'd0, 32'd1000);
      queue_speed(2'd0, 32'd1000);
      queue_pin(4'h0, 4'h0, 2'd0);
      queue_pin(4'hF, 4'h0, 2'd0);
      queue_speed(2'd0, 32'd1003);
      queue_speed(2'd1, 32'hFFFF_FFFF);
      queue_pin(4'h0, 4'hF, 2'd1);
      queue_pin(4'hF, 4'hF, 2'd1);
      queue_speed(2'd1, 32'd6);
      queue_speed(2'd2, 32'h8000_0000);
      queue_speed(2'd2, 32'h7FFF_FFFF);
      queue_speed(2'd3, 32'd1);
      queue_pin(4'h0, 4'h0, 2'd3);
      queue_pin(4'h8, 4'h8, 2'd3);
      queue_speed(2'd3, 32'd2);

      // random phases over several register settings
      program_wheels(4'hF, 4'h0);
      queue_random_items(175);
      program_wheels(4'hF, 4'hF);
      queue_random_items(175);
      program_wheels(4'h0, 4'hF);
      queue_random_items(175);
      program_wheels(qwc_pkg::PIN_WIDTH'($urandom), qwc_pkg::PIN_WIDTH'($urandom));
      queue_random_items(175);
      program_wheels(qwc_pkg::PIN_WIDTH'($urandom), qwc_pkg::PIN_WIDTH'($urandom));
      queue_random_items(175);
      program_wheels(4'hF, qwc_pkg::PIN_WIDTH'($urandom));
      queue_random_items(175);

      wait_idle();
      repeat (50) @(posedge clock);
      if (!mismatch_seen && expected_readings.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
